>>> rtl/core/swms_pkg.sv
// Shared types and constants of the sliding window mean and deviation block.
package swms_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 20;
    localparam int LEN_W    = 9;
    localparam int NORM_W   = 16;
    localparam int CFG_W    = 16;
    localparam int MEAN_W   = 24;
    localparam int SIGMA_W  = 24;
    localparam int RMEAN_W  = 25;
    localparam int SS_W     = 60;
    localparam int QDEPTH   = 2;

    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_WINDOW_LEN    = 1'b0;
    localparam t_reg_idx REG_NORM_CONSTANT = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first_sample;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0]          window_index;
        logic signed [MEAN_W-1:0]  mean;
        logic [SIGMA_W-1:0]        sigma;
    } t_out;

    // one classified sample, passed from the front end to the compute engine
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first;
        logic                       emit;
        logic                       exact;
        logic [CNT_W-1:0]           idx;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDB,
        S_WRITE,
        S_SUM,
        S_MDIV,
        S_SQ,
        S_IMUL1,
        S_IMUL2,
        S_IMUL3,
        S_IACC,
        S_NDIV,
        S_SQRT,
        S_OUT
    } t_state;

endpackage

>>> rtl/core/swms_ram.sv
// Generic single write, single read RAM with registered read data.
module swms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/swms_queue.sv
// Two-entry command queue between the front end and the compute engine.
module swms_queue
    import swms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_ready,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_data
);

    localparam int P_W = $clog2(QDEPTH);
    localparam int C_W = $clog2(QDEPTH + 1);

    t_cmd           r_mem [QDEPTH];
    logic [P_W-1:0] r_wp;
    logic [P_W-1:0] r_rp;
    logic [C_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= P_W'((32'(r_wp) + 1) % QDEPTH);
            end
            if (i_pop) begin
                r_rp <= P_W'((32'(r_rp) + 1) % QDEPTH);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_ready = (r_cnt != C_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_cnt == C_W'(QDEPTH) && !i_pop))
        else $error("command queue overflow");
`endif

endmodule

>>> rtl/core/swms_front.sv
// Front end: accepts samples, tracks series position and resync phase, classifies.
module swms_front
    import swms_pkg::*;
#(
    parameter int M_W = 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [M_W-1:0] i_m,
    input  logic           i_valid,
    output logic           o_ready,
    input  t_in            i_data,
    output logic           o_push,
    input  logic           i_q_ready,
    output t_cmd           o_cmd
);

    logic [CNT_W-1:0] r_cnt;
    logic             r_wrap;
    logic [M_W-1:0]   r_phase;

    logic [CNT_W-1:0] n_cnt;
    logic             n_wrap;
    logic [M_W-1:0]   n_phase;
    logic [CNT_W-1:0] base_cnt;
    logic             base_wrap;
    logic [M_W-1:0]   base_phase;
    logic [M_W-1:0]   phase_inc;
    logic             full;
    logic             exact;
    logic             accept;

    assign accept  = i_valid && i_q_ready;
    assign o_ready = i_q_ready;
    assign o_push  = accept;

    always_comb begin
        base_cnt   = i_data.first_sample ? '0 : r_cnt;
        base_wrap  = i_data.first_sample ? 1'b0 : r_wrap;
        base_phase = i_data.first_sample ? '0 : r_phase;
        n_cnt      = base_cnt + 1'b1;
        n_wrap     = base_wrap || (n_cnt == '0);
        full       = n_wrap || (n_cnt >= CNT_W'(i_m));
        exact      = (base_phase == '0) || (base_phase >= i_m);
        phase_inc  = (exact ? '0 : base_phase) + 1'b1;
        if (full) begin
            n_phase = (phase_inc >= i_m) ? '0 : phase_inc;
        end else begin
            n_phase = base_phase;
        end
        o_cmd.sample = i_data.sample;
        o_cmd.first  = i_data.first_sample;
        o_cmd.emit   = full;
        o_cmd.exact  = exact;
        o_cmd.idx    = n_cnt - CNT_W'(i_m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_wrap  <= 1'b0;
            r_phase <= '0;
        end else if (accept) begin
            r_cnt   <= n_cnt;
            r_wrap  <= n_wrap;
            r_phase <= n_phase;
        end
    end

endmodule

>>> rtl/core/swms_back.sv
// Compute engine: sample store, exact and incremental statistics, divide, root.
module swms_back
    import swms_pkg::*;
#(
    parameter int MAX_WINDOW = 256,
    parameter int M_W        = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [M_W-1:0]    i_m,
    input  logic [NORM_W-1:0] i_norm,
    input  logic              i_q_valid,
    output logic              o_q_pop,
    input  t_cmd              i_cmd,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data
);

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int AW     = PTR_W + 2;
    localparam int SUM_W  = SAMPLE_W + M_W + 1;
    localparam int MNUM_W = SUM_W + 8;
    localparam int D_W    = RMEAN_W + 1;
    localparam int P_W    = 2 * D_W;
    localparam int ACC_W  = (P_W + M_W > SS_W + 2) ? P_W + M_W : SS_W + 2;
    localparam int DIV_W  = SS_W;
    localparam int DC_W   = $clog2(DIV_W + 1);
    localparam int MS_W   = DIV_W + 2;
    localparam logic signed [MS_W-1:0] RM_MAX = MS_W'((64'sd1 <<< (RMEAN_W - 1)) - 1);
    localparam logic signed [MS_W-1:0] RM_MIN = -RM_MAX - 1;

    function automatic logic [PTR_W-1:0] f_wrap(input logic [AW-1:0] v);
        logic [AW-1:0] t;
        t = (v >= AW'(MAX_WINDOW)) ? v - AW'(MAX_WINDOW) : v;
        return t[PTR_W-1:0];
    endfunction

    t_state r_state, n_state;

    t_cmd                      r_cmd;
    logic [PTR_W-1:0]          r_wp;
    logic [PTR_W-1:0]          r_raddr;
    logic [M_W-1:0]            r_cnt;
    logic                      r_rvld, r_ovld, r_pvld;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [RMEAN_W-1:0] r_mu, r_prev;
    logic signed [SAMPLE_W-1:0] r_b;
    logic [SS_W-1:0]           r_ss;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [D_W-1:0]     r_mul_a, r_mul_b;
    logic signed [P_W-1:0]     r_prod, r_p1;
    logic [DIV_W-1:0]          r_dq;
    logic [NORM_W-1:0]         r_drem;
    logic [DC_W-1:0]           r_dcnt;
    logic                      r_dneg;
    logic [SS_W-1:0]           r_sv, r_sres, r_sbit;
    logic                      r_out_valid;
    t_out                      r_out_data;

    // engine control
    logic              ram_we;
    logic [PTR_W-1:0]  ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic              walk_issue;
    logic              div_done;
    logic              sqrt_done;
    logic              out_free;

    logic [PTR_W-1:0]  win_base;
    logic [PTR_W-1:0]  wp_next;

    logic signed [MNUM_W-1:0] sum_num, inc_num;
    logic [MNUM_W-1:0]        sum_mag, inc_mag;
    logic [NORM_W:0]          rem_sh;
    logic [NORM_W:0]          den;
    logic                     ge;
    logic [MS_W-1:0]          q_mag;
    logic signed [MS_W-1:0]   q_adj, mu_sum;
    logic signed [RMEAN_W-1:0] mu_new;
    logic signed [D_W-1:0]    x8, a8, b8;
    logic signed [ACC_W-1:0]  inc_ss;
    logic [SS_W-1:0]          acc_clamp, inc_clamp;
    logic [SS_W:0]            sq_t;
    logic [SIGMA_W-1:0]       sigma_sat;
    logic signed [MEAN_W-1:0] mean_sat;

    function automatic logic [SS_W-1:0] f_clamp_ss(input logic signed [ACC_W-1:0] v);
        logic [SS_W-1:0] r;
        if (v[ACC_W-1]) begin
            r = '0;
        end else if (|v[ACC_W-2:SS_W]) begin
            r = '1;
        end else begin
            r = v[SS_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        win_base = f_wrap(AW'(r_wp) + AW'(MAX_WINDOW) - AW'(i_m));
        wp_next  = f_wrap(AW'(r_wp) + 1'b1);
        sum_num  = MNUM_W'(r_sum) <<< 8;
        inc_num  = (MNUM_W'(r_cmd.sample) - MNUM_W'($signed(ram_rdata))) <<< 8;
        sum_mag  = sum_num[MNUM_W-1] ? -sum_num : sum_num;
        inc_mag  = inc_num[MNUM_W-1] ? -inc_num : inc_num;
        den      = (r_state == S_MDIV) ? (NORM_W + 1)'(i_m) : {1'b0, i_norm};
        rem_sh   = {r_drem, r_dq[DIV_W-1]};
        ge       = (rem_sh >= den);
        // round a negative quotient toward minus infinity
        q_mag    = MS_W'(r_dq) + MS_W'(r_dneg && (r_drem != '0));
        q_adj    = r_dneg ? -$signed(q_mag) : $signed(q_mag);
        mu_sum   = (r_cmd.exact ? '0 : MS_W'(r_mu)) + q_adj;
        if (mu_sum > RM_MAX) begin
            mu_new = RM_MAX[RMEAN_W-1:0];
        end else if (mu_sum < RM_MIN) begin
            mu_new = RM_MIN[RMEAN_W-1:0];
        end else begin
            mu_new = mu_sum[RMEAN_W-1:0];
        end
        x8        = (D_W'($signed(ram_rdata)) <<< 8) - D_W'(r_mu);
        a8        = D_W'(r_cmd.sample) <<< 8;
        b8        = D_W'(r_b) <<< 8;
        inc_ss    = $signed(ACC_W'(r_ss)) + ACC_W'(r_p1) - ACC_W'(r_prod);
        acc_clamp = f_clamp_ss(r_acc);
        inc_clamp = f_clamp_ss(inc_ss);
        sq_t      = (SS_W + 1)'(r_sres) + (SS_W + 1)'(r_sbit);
        sigma_sat = (|r_sres[SS_W-1:SIGMA_W]) ? '1 : r_sres[SIGMA_W-1:0];
        if (r_mu[RMEAN_W-1] != r_mu[RMEAN_W-2]) begin
            mean_sat = r_mu[RMEAN_W-1] ? {1'b1, {(MEAN_W-1){1'b0}}}
                                       : {1'b0, {(MEAN_W-1){1'b1}}};
        end else begin
            mean_sat = r_mu[MEAN_W-1:0];
        end
    end

    // FSM outputs
    always_comb begin
        walk_issue = ((r_state == S_SUM) || (r_state == S_SQ)) && (r_cnt != i_m);
        div_done   = (r_dcnt == DC_W'(DIV_W));
        sqrt_done  = (r_sbit == '0);
        out_free   = !r_out_valid || i_out_ready;
        o_q_pop    = (r_state == S_IDLE) && i_q_valid;
        ram_we     = (r_state == S_WRITE);
        ram_raddr  = (r_state == S_RDB) ? win_base : r_raddr;
    end

    // FSM next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_q_valid) n_state = S_RDB;
            S_RDB:   n_state = S_WRITE;
            S_WRITE: begin
                if (!r_cmd.emit) n_state = S_IDLE;
                else if (r_cmd.exact) n_state = S_SUM;
                else n_state = S_MDIV;
            end
            S_SUM:   if (!walk_issue && !r_rvld) n_state = S_MDIV;
            S_MDIV:  if (div_done) n_state = r_cmd.exact ? S_SQ : S_IMUL1;
            S_SQ: begin
                if (!walk_issue && !r_rvld && !r_ovld && !r_pvld) n_state = S_NDIV;
            end
            S_IMUL1: n_state = S_IMUL2;
            S_IMUL2: n_state = S_IMUL3;
            S_IMUL3: n_state = S_IACC;
            S_IACC:  n_state = S_NDIV;
            S_NDIV:  if (div_done) n_state = S_SQRT;
            S_SQRT:  if (sqrt_done) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rvld      <= 1'b0;
            r_ovld      <= 1'b0;
            r_pvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rvld  <= walk_issue;
            r_ovld  <= r_rvld && (r_state == S_SQ);
            r_pvld  <= r_ovld;
            if (o_q_pop && i_cmd.first) begin
                r_wp <= '0;
            end else if (r_state == S_WRITE) begin
                r_wp <= wp_next;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_mul_a * r_mul_b;
        if (o_q_pop) begin
            r_cmd <= i_cmd;
        end
        if (walk_issue) begin
            r_cnt   <= r_cnt + 1'b1;
            r_raddr <= f_wrap(AW'(r_raddr) + 1'b1);
        end
        if ((r_state == S_MDIV || r_state == S_NDIV) && !div_done) begin
            r_drem <= ge ? NORM_W'(rem_sh - den) : rem_sh[NORM_W-1:0];
            r_dq   <= {r_dq[DIV_W-2:0], ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
        unique case (r_state)
            S_WRITE: begin
                r_b     <= $signed(ram_rdata);
                r_cnt   <= '0;
                r_raddr <= f_wrap(AW'(win_base) + 1'b1);
                r_sum   <= '0;
                r_dq    <= DIV_W'(inc_mag);
                r_dneg  <= inc_num[MNUM_W-1];
                r_drem  <= '0;
                r_dcnt  <= '0;
            end
            S_SUM: begin
                if (r_rvld) begin
                    r_sum <= r_sum + SUM_W'($signed(ram_rdata));
                end
                if (!walk_issue && !r_rvld) begin
                    r_dq   <= DIV_W'(sum_mag);
                    r_dneg <= sum_num[MNUM_W-1];
                    r_drem <= '0;
                    r_dcnt <= '0;
                end
            end
            S_MDIV: begin
                if (div_done) begin
                    r_prev  <= r_mu;
                    r_mu    <= mu_new;
                    r_cnt   <= '0;
                    r_raddr <= win_base;
                    r_acc   <= '0;
                end
            end
            S_SQ: begin
                if (r_rvld) begin
                    r_mul_a <= x8;
                    r_mul_b <= x8;
                end
                if (r_pvld) begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
                if (!walk_issue && !r_rvld && !r_ovld && !r_pvld) begin
                    r_ss   <= acc_clamp;
                    r_dq   <= acc_clamp;
                    r_drem <= '0;
                    r_dcnt <= '0;
                end
            end
            S_IMUL1: begin
                r_mul_a <= a8 - D_W'(r_mu);
                r_mul_b <= a8 - D_W'(r_prev);
            end
            S_IMUL2: begin
                r_mul_a <= b8 - D_W'(r_mu);
                r_mul_b <= b8 - D_W'(r_prev);
            end
            S_IMUL3: r_p1 <= r_prod;
            S_IACC: begin
                r_ss   <= inc_clamp;
                r_dq   <= inc_clamp;
                r_drem <= '0;
                r_dcnt <= '0;
            end
            S_NDIV: begin
                if (div_done) begin
                    r_sv   <= r_dq;
                    r_sres <= '0;
                    r_sbit <= SS_W'(1) << (SS_W - 2);
                end
            end
            S_SQRT: begin
                if (!sqrt_done) begin
                    if ((SS_W + 1)'(r_sv) >= sq_t) begin
                        r_sv   <= r_sv - sq_t[SS_W-1:0];
                        r_sres <= (r_sres >> 1) + r_sbit;
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_data.window_index <= r_cmd.idx;
                    r_out_data.mean         <= mean_sat;
                    r_out_data.sigma        <= sigma_sat;
                end
            end
            default: begin
            end
        endcase
    end

    swms_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_cmd.sample),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_rvld_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rvld |-> (r_state == S_SUM || r_state == S_SQ))
        else $error("store read data outside a walk");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM || r_state == S_SQ) |-> (r_cnt <= i_m))
        else $error("walk ran past the window");
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_sres[SS_W-1:SS_W/2] == '0))
        else $error("square root out of range");
`endif

endmodule

>>> rtl/core/sliding_window_mean_std_top.sv
// Top level of the sliding window mean and deviation block.
//
//  channel   direction  handshake                        payload
//  in        sink       i_in_valid / o_in_ready          t_in  (sample, first_sample)
//  out       source     o_out_valid / i_out_ready        t_out (window_index, mean, sigma)
//  cfg       sink       i_cfg_we (no wait)               i_cfg_idx, i_cfg_data
//
// A sample that completes no window needs only the store read and write.
// An incremental window passes through store access, the mean divide, two products,
// a 60-step normalizing divide, a 30-step square root and the output.
// An exact resync window replaces the products by two walks over the store.
// The engine handles one transaction at a time; a two-entry queue lets the
// front end take samples meanwhile, and the output register holds a result
// while the sink stalls. Reset is synchronous and active low; the store has
// no clearing pass.
module sliding_window_mean_std_top
    import swms_pkg::*;
#(
    parameter int MAX_WINDOW = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data,
    input  logic             i_cfg_we,
    input  t_reg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int M_W = $clog2(MAX_WINDOW + 1);

    logic [LEN_W-1:0]  r_window_len;
    logic [NORM_W-1:0] r_norm_constant;

    logic [M_W-1:0]    m_eff;
    logic [NORM_W-1:0] norm_eff;

    logic q_push, q_ready, q_valid, q_pop;
    t_cmd front_cmd, q_cmd;

    // hold configuration; users write only while the engine is idle, not enforced here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len    <= LEN_W'(16);
            r_norm_constant <= NORM_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WINDOW_LEN:    r_window_len    <= i_cfg_data[LEN_W-1:0];
                REG_NORM_CONSTANT: r_norm_constant <= i_cfg_data[NORM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // saturate the window length into the supported range, treat zero norm as one
    always_comb begin
        if (r_window_len < LEN_W'(2)) begin
            m_eff = M_W'(2);
        end else if (32'(r_window_len) > MAX_WINDOW) begin
            m_eff = M_W'(MAX_WINDOW);
        end else begin
            m_eff = M_W'(r_window_len);
        end
        norm_eff = (r_norm_constant == '0) ? NORM_W'(1) : r_norm_constant;
    end

    swms_front #(
        .M_W (M_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_m       (m_eff),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_data    (i_in_data),
        .o_push    (q_push),
        .i_q_ready (q_ready),
        .o_cmd     (front_cmd)
    );

    swms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_cmd)
    );

    swms_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .M_W        (M_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_m         (m_eff),
        .i_norm      (norm_eff),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
